// ===== hdl/tpd_pkg.sv =====
// shared constants, types and command codes for the tree path distance block
`timescale 1ns / 1ps
package tpd_pkg;
  localparam int MAX_NODES   = 1024;
  localparam int MAX_EDGES   = 2048;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int EIDX_W      = $clog2(MAX_EDGES);
  localparam int CUR_W       = EIDX_W + 1;
  localparam int WEIGHT_BITS = 16;
  localparam int DIST_W      = 32;
  localparam int SP_W        = NODE_W + 1;
  localparam int STK_W       = CUR_W + DIST_W;
  localparam int EINFO_W     = NODE_W + WEIGHT_BITS;

  localparam logic [CUR_W-1:0]  NO_EDGE   = CUR_W'(MAX_EDGES);
  localparam logic [CUR_W-1:0]  FULL_MARK = CUR_W'(MAX_EDGES - 2);
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_HEAD_CLR,
    CMD_VIS_CLR,
    CMD_ROOT,
    CMD_ROOT_LD,
    CMD_EDGE_GOT,
    CMD_PUSH,
    CMD_POP,
    CMD_POP_LD,
    CMD_AP_RD,
    CMD_AP_WR,
    CMD_AP_LINK,
    CMD_AP_NEXT,
    CMD_OUT_ZERO,
    CMD_OUT_FOUND
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t    cmd;
    logic [1:0] res;
  } dp_ctrl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       a_eq_b;
    logic       full;
    logic       sweep_last;
    logic       cur_empty;
    logic       pop_last;
    logic       visited;
    logic       hit;
    logic       stack_full;
    logic       head_empty;
    logic       second;
  } dp_stat_t;
endpackage

// ===== hdl/tpd_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module tpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/tpd_ctrl.sv =====
// controller state machine sequencing edge inserts, clears and the walk
`timescale 1ns / 1ps
module tpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tpd_pkg::dp_stat_t stat,
  output tpd_pkg::dp_ctrl_t ctrl
);
  import tpd_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_CLR, S_AP_RD, S_AP_WR, S_AP_LINK, S_AP_END,
    S_VCLR, S_ROOT, S_ROOT_LD, S_EDGE, S_POP_LD, S_EDGE_GOT, S_CHECK,
    S_OUT_OK, S_OUT_NF, S_OUT_FULL, S_OUT_FOUND
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl.cmd  = CMD_NONE;
    ctrl.res  = ST_OK;
    case (state_r)
      S_INIT: begin
        ctrl.cmd = CMD_HEAD_CLR;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctrl.cmd  = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_ADD:   state_nxt = stat.full ? S_OUT_FULL : S_AP_RD;
          OP_QUERY: state_nxt = stat.a_eq_b ? S_OUT_OK : S_VCLR;
          OP_CLEAR: state_nxt = S_CLR;
          default:  state_nxt = S_OUT_OK;
        endcase
      end
      S_CLR: begin
        ctrl.cmd = CMD_HEAD_CLR;
        if (stat.sweep_last) state_nxt = S_OUT_OK;
      end
      S_AP_RD: begin
        ctrl.cmd  = CMD_AP_RD;
        state_nxt = S_AP_WR;
      end
      S_AP_WR: begin
        ctrl.cmd  = CMD_AP_WR;
        state_nxt = stat.head_empty ? S_AP_END : S_AP_LINK;
      end
      S_AP_LINK: begin
        ctrl.cmd  = CMD_AP_LINK;
        state_nxt = S_AP_END;
      end
      S_AP_END: begin
        if (stat.second) begin
          state_nxt = S_OUT_OK;
        end else begin
          ctrl.cmd  = CMD_AP_NEXT;
          state_nxt = S_AP_RD;
        end
      end
      S_VCLR: begin
        ctrl.cmd = CMD_VIS_CLR;
        if (stat.sweep_last) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        ctrl.cmd  = CMD_ROOT;
        state_nxt = S_ROOT_LD;
      end
      S_ROOT_LD: begin
        ctrl.cmd  = CMD_ROOT_LD;
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        if (stat.cur_empty) begin
          ctrl.cmd  = CMD_POP;
          state_nxt = stat.pop_last ? S_OUT_NF : S_POP_LD;
        end else begin
          state_nxt = S_EDGE_GOT;
        end
      end
      S_POP_LD: begin
        ctrl.cmd  = CMD_POP_LD;
        state_nxt = S_EDGE;
      end
      S_EDGE_GOT: begin
        ctrl.cmd  = CMD_EDGE_GOT;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.visited) begin
          state_nxt = S_EDGE;
        end else if (stat.hit) begin
          state_nxt = S_OUT_FOUND;
        end else if (stat.stack_full) begin
          state_nxt = S_EDGE;
        end else begin
          ctrl.cmd  = CMD_PUSH;
          state_nxt = S_EDGE;
        end
      end
      S_OUT_OK: begin
        ctrl.cmd  = CMD_OUT_ZERO;
        state_nxt = S_IDLE;
      end
      S_OUT_NF: begin
        ctrl.cmd  = CMD_OUT_ZERO;
        ctrl.res  = ST_NOT_FOUND;
        state_nxt = S_IDLE;
      end
      S_OUT_FULL: begin
        ctrl.cmd  = CMD_OUT_ZERO;
        ctrl.res  = ST_FULL;
        state_nxt = S_IDLE;
      end
      S_OUT_FOUND: begin
        ctrl.cmd  = CMD_OUT_FOUND;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== hdl/tpd_dp.sv =====
// datapath with adjacency tables, visited marks, walk stack and result registers
`timescale 1ns / 1ps
module tpd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tpd_pkg::dp_ctrl_t                 ctrl,
  output tpd_pkg::dp_stat_t                 stat,
  input  logic [1:0]                        in_operation,
  input  logic [tpd_pkg::NODE_W-1:0]        in_node_a,
  input  logic [tpd_pkg::NODE_W-1:0]        in_node_b,
  input  logic [tpd_pkg::WEIGHT_BITS-1:0]   in_weight,
  output logic                              out_valid,
  output logic [tpd_pkg::DIST_W-1:0]        out_distance,
  output logic [1:0]                        out_status
);
  import tpd_pkg::*;

  logic [1:0]             op_r;
  logic [NODE_W-1:0]      a_r, b_r, v_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic [NODE_W-1:0]      sweep_r;
  logic [CUR_W-1:0]       cnt_r;
  logic                   second_r;
  logic [SP_W-1:0]        sp_r;
  logic [CUR_W-1:0]       cur_r;
  logic [DIST_W-1:0]      dist_r, nd_r;
  logic [EIDX_W-1:0]      tail_r;

  logic [NODE_W-1:0]  from_node, to_node;
  logic [EIDX_W-1:0]  e_idx, e_prev;
  logic [DIST_W:0]    sum;

  logic                head_we, tail_we, einfo_we, enext_we, vis_we, stk_we;
  logic [NODE_W-1:0]   head_wa, head_ra, tail_ra, vis_wa, vis_ra, stk_wa, stk_ra;
  logic [CUR_W-1:0]    head_wd, head_rd, enext_wd, enext_rd;
  logic [EIDX_W-1:0]   tail_rd, enext_wa;
  logic [EINFO_W-1:0]  einfo_rd;
  logic                vis_wd, vis_rd;
  logic [STK_W-1:0]    stk_rd;

  assign from_node = second_r ? b_r : a_r;
  assign to_node   = second_r ? a_r : b_r;
  assign e_idx     = cnt_r[EIDX_W-1:0];
  assign e_prev    = EIDX_W'(cnt_r - CUR_W'(1));
  assign sum       = {1'b0, dist_r} + (DIST_W+1)'(einfo_rd[WEIGHT_BITS-1:0]);

  always_comb begin
    head_we  = 1'b0;
    head_wa  = sweep_r;
    head_wd  = NO_EDGE;
    head_ra  = a_r;
    tail_we  = 1'b0;
    tail_ra  = from_node;
    einfo_we = 1'b0;
    enext_we = 1'b0;
    enext_wa = e_idx;
    enext_wd = NO_EDGE;
    vis_we   = 1'b0;
    vis_wa   = sweep_r;
    vis_wd   = 1'b0;
    vis_ra   = einfo_rd[EINFO_W-1:WEIGHT_BITS];
    stk_we   = 1'b0;
    stk_wa   = NODE_W'(sp_r - SP_W'(1));
    stk_ra   = NODE_W'(sp_r - SP_W'(2));
    case (ctrl.cmd)
      CMD_HEAD_CLR: head_we = 1'b1;
      CMD_VIS_CLR:  vis_we = 1'b1;
      CMD_ROOT: begin
        vis_we = 1'b1;
        vis_wa = a_r;
        vis_wd = 1'b1;
      end
      CMD_EDGE_GOT: head_ra = einfo_rd[EINFO_W-1:WEIGHT_BITS];
      CMD_PUSH: begin
        stk_we = 1'b1;
        vis_we = 1'b1;
        vis_wa = v_r;
        vis_wd = 1'b1;
      end
      CMD_AP_RD: head_ra = from_node;
      CMD_AP_WR: begin
        einfo_we = 1'b1;
        enext_we = 1'b1;
        tail_we  = 1'b1;
        head_we  = head_rd[CUR_W-1];
        head_wa  = from_node;
        head_wd  = {1'b0, e_idx};
      end
      CMD_AP_LINK: begin
        enext_we = 1'b1;
        enext_wa = tail_r;
        enext_wd = {1'b0, e_prev};
      end
      default: ;
    endcase
  end

  tpd_ram #(.WIDTH(CUR_W), .DEPTH(MAX_NODES)) u_head (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd)
  );
  tpd_ram #(.WIDTH(EIDX_W), .DEPTH(MAX_NODES)) u_tail (
    .clk, .we(tail_we), .waddr(from_node), .wdata(e_idx), .raddr(tail_ra), .rdata(tail_rd)
  );
  tpd_ram #(.WIDTH(EINFO_W), .DEPTH(MAX_EDGES)) u_einfo (
    .clk, .we(einfo_we), .waddr(e_idx), .wdata({to_node, w_r}),
    .raddr(cur_r[EIDX_W-1:0]), .rdata(einfo_rd)
  );
  tpd_ram #(.WIDTH(CUR_W), .DEPTH(MAX_EDGES)) u_enext (
    .clk, .we(enext_we), .waddr(enext_wa), .wdata(enext_wd),
    .raddr(cur_r[EIDX_W-1:0]), .rdata(enext_rd)
  );
  tpd_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (
    .clk, .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd)
  );
  tpd_ram #(.WIDTH(STK_W), .DEPTH(MAX_NODES)) u_stack (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata({cur_r, dist_r}), .raddr(stk_ra), .rdata(stk_rd)
  );

  always_comb begin
    stat.op         = op_r;
    stat.a_eq_b     = (a_r == b_r);
    stat.full       = (cnt_r > FULL_MARK);
    stat.sweep_last = (sweep_r == '1);
    stat.cur_empty  = cur_r[CUR_W-1];
    stat.pop_last   = (sp_r == SP_W'(1));
    stat.visited    = vis_rd;
    stat.hit        = (v_r == b_r);
    stat.stack_full = sp_r[SP_W-1];
    stat.head_empty = head_rd[CUR_W-1];
    stat.second     = second_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r   <= '0;
      cnt_r     <= '0;
      sp_r      <= '0;
      second_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (ctrl.cmd)
        CMD_LOAD: second_r <= 1'b0;
        CMD_HEAD_CLR: begin
          sweep_r <= sweep_r + NODE_W'(1);
          cnt_r   <= '0;
        end
        CMD_VIS_CLR:  sweep_r <= sweep_r + NODE_W'(1);
        CMD_ROOT:     sp_r <= SP_W'(1);
        CMD_PUSH:     sp_r <= sp_r + SP_W'(1);
        CMD_POP:      sp_r <= sp_r - SP_W'(1);
        CMD_AP_WR:    cnt_r <= cnt_r + CUR_W'(1);
        CMD_AP_NEXT:  second_r <= 1'b1;
        CMD_OUT_ZERO, CMD_OUT_FOUND: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_LOAD: begin
        op_r <= in_operation;
        a_r  <= in_node_a;
        b_r  <= in_node_b;
        w_r  <= in_weight;
      end
      CMD_ROOT:    dist_r <= '0;
      CMD_ROOT_LD: cur_r <= head_rd;
      CMD_EDGE_GOT: begin
        cur_r <= enext_rd;
        v_r   <= einfo_rd[EINFO_W-1:WEIGHT_BITS];
        nd_r  <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
      end
      CMD_PUSH: begin
        cur_r  <= head_rd;
        dist_r <= nd_r;
      end
      CMD_POP_LD: {cur_r, dist_r} <= stk_rd;
      CMD_AP_WR:  tail_r <= tail_rd;
      CMD_OUT_ZERO: begin
        out_distance <= '0;
        out_status   <= ctrl.res;
      end
      CMD_OUT_FOUND: begin
        out_distance <= nd_r;
        out_status   <= ST_OK;
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/tree_path_distance.sv =====
// top level of the weighted tree store with path distance queries
// add stores both edge directions unless the table is full; clear sweeps all list heads
// query clears visited marks and walks from a, unless start and target are equal
// throughput: one item at a time; busy stays high until the result strobe
// reset: synchronous active low, then a sweep of all list heads with busy high
// results show on out_valid for one cycle and cannot be stalled
`timescale 1ns / 1ps
module tree_path_distance (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_operation,
  input  logic [tpd_pkg::NODE_W-1:0]      in_node_a,
  input  logic [tpd_pkg::NODE_W-1:0]      in_node_b,
  input  logic [tpd_pkg::WEIGHT_BITS-1:0] in_weight,
  output logic                            out_valid,
  output logic [tpd_pkg::DIST_W-1:0]      out_distance,
  output logic [1:0]                      out_status
);
  import tpd_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  tpd_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .stat, .ctrl
  );

  tpd_dp u_dp (
    .clk, .rst_n, .ctrl, .stat, .in_operation, .in_node_a, .in_node_b, .in_weight,
    .out_valid, .out_distance, .out_status
  );

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after accepted item");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_distance == '0))
    else $error("nonzero distance on failed item");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOT_FOUND ||
                   out_status == ST_FULL)) else $error("bad status code");
`endif
endmodule
